// ===== rtl/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// Used by hcbp_ctrl, hcbp_datapath and huffman_code_bit_packer_top; no dependencies.
package hcbp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int LEN_BITS  = 6;
    localparam int ACC_BITS  = WORD_BITS + BYTE_BITS;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]           func;
        logic [7:0]           symbol;
        logic [WORD_BITS-1:0] code_word;
        logic [LEN_BITS-1:0]  code_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic wr;     // write table entry from the input request
        logic rd;     // read table entry for the input symbol
        logic flush;  // promote the partial byte to a full byte
        logic merge;  // append looked-up code bits to the accumulator
        logic emit;   // move one byte to the output register
    } t_cmd;

    typedef struct packed {
        logic part_nz;   // partial byte holds at least one bit
        logic merge_ge8; // merged bit count reaches a full byte
        logic ge8;       // accumulator holds a full byte
        logic last;      // the byte at hand is the final one of the request
        logic out_free;  // output register can take a byte this cycle
    } t_status;

endpackage

// ===== rtl/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer: state machine plus datapath.
// Depends on hcbp_pkg, hcbp_ctrl and hcbp_datapath.
//
// Takes one request at a time. A load request writes a symbol's code word and
// length (saturated to MAX_CODE_LEN and 32) to the tables. An encode
// request reads the table through the single registered read port, merges the
// looked-up bits and then emits up to four bytes, one per cycle while the output
// side takes a byte every cycle; the one-byte output register holds each byte
// until it is taken. A flush request with an empty partial byte ends without
// output; otherwise it emits the zero-padded partial byte. The final byte
// of each request carries last_of_run. The code tables read as zero length until
// a symbol is loaded; no clearing pass is needed after reset.
module huffman_code_bit_packer_top
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd    cmd;
    t_status sts;

    hcbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (t_func'(i_in.func)),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    hcbp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/hcbp_ctrl.sv =====
// Sequencing state machine of the Huffman code bit packer.
// Depends on hcbp_pkg for command, status and function code types.
module hcbp_ctrl
    import hcbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_func   i_func,
    input  t_status i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.wr = 1'b1;
                        end
                        FUNC_ENCODE: begin
                            o_cmd.rd = 1'b1;
                            n_state  = ST_LOOKUP;
                        end
                        FUNC_FLUSH: begin
                            o_cmd.flush = 1'b1;
                            if (i_sts.part_nz) begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                o_cmd.merge = 1'b1;
                n_state     = i_sts.merge_ge8 ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!i_sts.ge8) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The lookup state is never held: the merge always follows the table read in the next cycle.
    a_lookup_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOKUP |=> r_state != ST_LOOKUP)
        else $error("lookup state held for more than one cycle");

endmodule

// ===== rtl/hcbp_datapath.sv =====
// Code tables, bit accumulator and output register of the Huffman code bit packer.
// Depends on hcbp_pkg; driven by commands from hcbp_ctrl.
module hcbp_datapath
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in,
    input  t_cmd    i_cmd,
    input  logic    i_out_ready,
    output t_status o_sts,
    output logic    o_out_valid,
    output t_out    o_out
);

    localparam int AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIM = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    logic [WORD_BITS-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_BITS-1:0]  len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_vld;

    logic [WORD_BITS-1:0] r_rd_code;
    logic [LEN_BITS-1:0]  r_rd_len;
    logic                 r_rd_vld;

    logic [ACC_BITS-1:0]  r_acc;
    logic [LEN_BITS-1:0]  r_total;
    logic                 r_out_vld;
    t_out                 r_out;

    logic [AW-1:0]        idx;
    logic                 sym_ok;
    logic [LEN_BITS-1:0]  len_sat;
    logic [LEN_BITS-1:0]  eff_len;
    logic [WORD_BITS-1:0] masked;
    logic [ACC_BITS-1:0]  merged_acc;
    logic [LEN_BITS-1:0]  merged_total;

    assign idx     = i_in.symbol[AW-1:0];
    assign sym_ok  = ({1'b0, i_in.symbol} < 9'(SYMBOL_COUNT));
    assign len_sat = (i_in.code_length > LEN_BITS'(LEN_LIM)) ? LEN_BITS'(LEN_LIM)
                                                             : i_in.code_length;

    // Table memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && sym_ok) begin
            code_mem[idx] <= i_in.code_word;
            len_mem[idx]  <= len_sat;
        end
        if (i_cmd.rd) begin
            r_rd_code <= code_mem[idx];
            r_rd_len  <= len_mem[idx];
        end
    end

    // Entries never written since reset read as length zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr && sym_ok) begin
                r_vld[idx] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= sym_ok && r_vld[idx];
            end
        end
    end

    assign eff_len = r_rd_vld ? r_rd_len : '0;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            masked[j] = r_rd_code[j] && (LEN_BITS'(j) < eff_len);
        end
    end

    assign merged_acc   = r_acc | (ACC_BITS'(masked) << r_total[2:0]);
    assign merged_total = {{(LEN_BITS-3){1'b0}}, r_total[2:0]} + eff_len;

    // Bits above r_total in the accumulator are always zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_total <= '0;
        end else if (i_cmd.merge) begin
            r_acc   <= merged_acc;
            r_total <= merged_total;
        end else if (i_cmd.flush) begin
            r_total <= o_sts.part_nz ? LEN_BITS'(BYTE_BITS) : '0;
        end else if (i_cmd.emit) begin
            r_acc   <= r_acc >> BYTE_BITS;
            r_total <= r_total - LEN_BITS'(BYTE_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte    <= r_acc[BYTE_BITS-1:0];
            r_out.last_of_run <= o_sts.last;
        end
    end

    assign o_sts.part_nz   = (r_total[2:0] != 3'd0);
    assign o_sts.merge_ge8 = (merged_total >= LEN_BITS'(BYTE_BITS));
    assign o_sts.ge8       = (r_total >= LEN_BITS'(BYTE_BITS));
    assign o_sts.last      = (r_total < LEN_BITS'(2 * BYTE_BITS));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_total >= LEN_BITS'(BYTE_BITS))
        else $error("byte emitted from a partly filled accumulator");

    a_emit_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && o_sts.last |=> r_total < LEN_BITS'(BYTE_BITS))
        else $error("full byte left behind after the final byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |-> !i_cmd.emit)
        else $error("output byte overwritten before it was taken");

endmodule

// ===== verif/tb_huffman_code_bit_packer_top.sv =====
// Self-checking testbench for huffman_code_bit_packer_top: directed and random requests
// with a scoreboard class that predicts the packed byte stream. Depends on hcbp_pkg.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_top
    import hcbp_pkg::*;
;

    class byte_stream_scoreboard;
        localparam int SYM_COUNT = 256;
        localparam int MAX_LEN   = 32;

        logic [WORD_BITS-1:0] code_mem [SYM_COUNT];
        logic [LEN_BITS-1:0]  len_mem  [SYM_COUNT];
        logic [7:0]           acc_byte;
        logic [2:0]           fill;
        t_out                 expected_bytes [$];
        int                   mismatches;

        function new();
            for (int s = 0; s < SYM_COUNT; s++) begin
                code_mem[s] = '0;
                len_mem[s]  = '0;
            end
            acc_byte   = '0;
            fill       = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction

        // Works out the bytes that one accepted request will produce.
        function void absorb_request(input t_in req);
            int   len;
            int   nbytes;
            int   k;
            t_out b;
            len = 0;
            k   = 0;
            case (req.func)
                FUNC_LOAD: begin
                    if (int'(req.symbol) < SYM_COUNT) begin
                        len = int'(req.code_length);
                        if (len > WORD_BITS) len = WORD_BITS;
                        if (len > MAX_LEN) len = MAX_LEN;
                        code_mem[req.symbol] = req.code_word;
                        len_mem[req.symbol]  = LEN_BITS'(len);
                    end
                end
                FUNC_ENCODE: begin
                    if (int'(req.symbol) < SYM_COUNT) begin
                        len = int'(len_mem[req.symbol]);
                        nbytes = (int'(fill) + len) / BYTE_BITS;
                        for (int j = 0; j < len; j++) begin
                            if (code_mem[req.symbol][j]) acc_byte[fill] = 1'b1;
                            if (fill == 3'd7) begin
                                k++;
                                b.out_byte    = acc_byte;
                                b.last_of_run = (k == nbytes);
                                expected_bytes.push_back(b);
                                acc_byte = '0;
                                fill     = '0;
                            end else begin
                                fill = fill + 3'd1;
                            end
                        end
                    end
                end
                FUNC_FLUSH: begin
                    if (fill != 3'd0) begin
                        b.out_byte    = acc_byte;
                        b.last_of_run = 1'b1;
                        expected_bytes.push_back(b);
                    end
                    acc_byte = '0;
                    fill     = '0;
                end
                default: begin
                end
            endcase
        endfunction

        task check_byte(input t_out got);
            t_out want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          got.out_byte, got.last_of_run));
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte got %02h want %02h",
                                              got.out_byte, want.out_byte));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %0b want %0b (byte %02h)",
                                              got.last_of_run, want.last_of_run,
                                              want.out_byte));
            end
        endtask
    endclass

    localparam int STALL_LIMIT = 2000;
    localparam int END_WAIT    = 20;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    byte_stream_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    huffman_code_bit_packer_top #(
        .MAX_CODE_LEN(32),
        .SYMBOL_COUNT(256)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Output is checked before the input is absorbed, since a byte leaving in the
    // same cycle always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_byte(o_out);
            if (i_in_valid && o_in_ready) sb.absorb_request(i_in);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL huffman_code_bit_packer_top");
            $finish;
        end
    end

    function automatic t_in make_request(input t_func func, input logic [7:0] sym,
                                         input logic [31:0] word, input logic [5:0] len);
        t_in r;
        r.func        = func;
        r.symbol      = sym;
        r.code_word   = word;
        r.code_length = len;
        return r;
    endfunction

    // Valid is only lowered when an idle gap follows, so it is never dropped and
    // raised within one step.
    task automatic send_request(input t_in req);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int n_items, input bit hold_off);
        int          count;
        int          roll;
        int          len_roll;
        logic [7:0]  sym;
        logic [5:0]  len;
        count = 0;
        while (count < n_items) begin
            roll     = $urandom_range(99);
            len_roll = $urandom_range(99);
            sym      = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(15));
            if (len_roll < 70)      len = 6'($urandom_range(12, 1));
            else if (len_roll < 90) len = 6'($urandom_range(32, 13));
            else if (len_roll < 95) len = 6'($urandom_range(63, 33));
            else                    len = '0;
            if (roll < 20) begin
                send_request(make_request(FUNC_LOAD, sym, $urandom, len));
            end else if (roll < 84) begin
                send_request(make_request(FUNC_ENCODE, sym, $urandom, len));
            end else if (roll < 95) begin
                send_request(make_request(FUNC_FLUSH, sym, $urandom, len));
            end else begin
                send_request(make_request(FUNC_RSVD, sym, $urandom, len));
            end
            count++;
            if (hold_off && count == n_items / 2) drain_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: unloaded symbol, empty flush, unused func, length
        // saturation, zero length, exact byte, and the widest byte runs.
        send_request(make_request(FUNC_ENCODE, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_RSVD, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
        send_request(make_request(FUNC_LOAD, 8'd0, 32'h1, 6'd1));
        send_request(make_request(FUNC_ENCODE, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32));
        send_request(make_request(FUNC_ENCODE, 8'd255, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd1, 32'hA5A5_5A5A, 6'd63));
        send_request(make_request(FUNC_ENCODE, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_ENCODE, 8'd1, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd0));
        send_request(make_request(FUNC_ENCODE, 8'd2, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd3, 32'h0000_0055, 6'd7));
        send_request(make_request(FUNC_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_ENCODE, 8'd3, 32'h0, 6'd0));
        send_request(make_request(FUNC_ENCODE, 8'd1, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd128, 32'h8000_0001, 6'd33));
        send_request(make_request(FUNC_ENCODE, 8'd128, 32'h0, 6'd0));
        send_request(make_request(FUNC_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd4, 32'h0000_00C3, 6'd8));
        send_request(make_request(FUNC_ENCODE, 8'd4, 32'h0, 6'd0));
        send_request(make_request(FUNC_FLUSH, 8'd0, 32'h0, 6'd0));
        send_request(make_request(FUNC_LOAD, 8'd0, 32'h0000_0002, 6'd3));
        send_request(make_request(FUNC_ENCODE, 8'd0, 32'h0, 6'd0));
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(76, 1'b0);
        drain_results();
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        run_random_phase(76, 1'b1);
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_random_phase(76, 1'b0);
        drain_results();
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random_phase(77, 1'b0);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d bytes never arrived", sb.pending()));

        if (sb.mismatches == 0) begin
            $display("PASS huffman_code_bit_packer_top");
        end else begin
            $display("FAIL huffman_code_bit_packer_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hcbp_pkg.sv
rtl/hcbp_ctrl.sv
rtl/hcbp_datapath.sv
rtl/huffman_code_bit_packer_top.sv
verif/tb_huffman_code_bit_packer_top.sv
